// ----- sv/mpm_pkg.sv -----
// shared constants and control types for the masked pixel mean block
package mpm_pkg;

  localparam int IDX_W       = 12;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 24;
  localparam int CNT_W       = 9;
  localparam int TEMP_W      = 18;

  localparam int TILE_PIXELS = 4096;
  localparam int ADDR_W      = $clog2(TILE_PIXELS);
  localparam int MAX_IMAGES  = 256;
  localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
  localparam int COUNT_LIMIT = (MAX_IMAGES < CNT_FIELD_MAX) ? MAX_IMAGES : CNT_FIELD_MAX;

  localparam int WORD_W      = SUM_W + CNT_W;

  // divider operands: num = 4*sum + count, den = 2*count
  localparam int NUM_W       = SUM_W + 3;
  localparam int DEN_W       = CNT_W + 1;
  localparam int REM_W       = DEN_W + 1;
  localparam int ITER_W      = $clog2(NUM_W + 1);

  localparam int KELVIN_OFFSET = 27315;
  localparam int TEMP_MAX      = (1 << (TEMP_W - 1)) - 1;
  localparam int QUOT_CLAMP    = TEMP_MAX + KELVIN_OFFSET;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic update_wr;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last_item;
    logic div_done;
  } sts_t;

endpackage

// ----- sv/mpm_div.sv -----
// restoring divider, one quotient bit per cycle
module mpm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mpm_pkg::NUM_W-1:0]  num,
  input  logic [mpm_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [mpm_pkg::NUM_W-1:0]  quot
);

  logic                        run_r;
  logic                        run_nxt;
  logic [mpm_pkg::ITER_W-1:0]  iter_r;
  logic [mpm_pkg::ITER_W-1:0]  iter_nxt;
  logic [mpm_pkg::NUM_W-1:0]   num_r;
  logic [mpm_pkg::NUM_W-1:0]   num_nxt;
  logic [mpm_pkg::DEN_W-1:0]   den_r;
  logic [mpm_pkg::DEN_W-1:0]   den_nxt;
  logic [mpm_pkg::REM_W-1:0]   rem_r;
  logic [mpm_pkg::REM_W-1:0]   rem_nxt;
  logic [mpm_pkg::REM_W-1:0]   rem_sh;
  logic                        qbit;

  assign done = run_r && (iter_r == '0);
  assign quot = num_r;

  always_comb begin
    rem_sh   = {rem_r[mpm_pkg::REM_W-2:0], num_r[mpm_pkg::NUM_W-1]};
    qbit     = (rem_sh >= {1'b0, den_r});
    run_nxt  = run_r;
    iter_nxt = iter_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      iter_nxt = mpm_pkg::ITER_W'(mpm_pkg::NUM_W);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (run_r) begin
      if (iter_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        iter_nxt = iter_r - 1'b1;
        rem_nxt  = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
        // quotient bits shift in behind the numerator
        num_nxt  = {num_r[mpm_pkg::NUM_W-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      iter_r <= '0;
    end else begin
      run_r  <= run_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ----- sv/mpm_dpath.sv -----
// datapath: pixel store, accumulate, divide and temperature result
module mpm_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpm_pkg::cmd_t                cmd,
  output mpm_pkg::sts_t                sts,
  input  logic                         cfg_we,
  input  logic [mpm_pkg::SAMPLE_W-1:0] cfg_null_value,
  input  logic [mpm_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [mpm_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                         in_last_image,
  output logic                         out_valid,
  output logic [mpm_pkg::IDX_W-1:0]    out_pixel_index_out,
  output logic signed [mpm_pkg::TEMP_W-1:0] out_temperature,
  output logic [mpm_pkg::CNT_W-1:0]    out_valid_count
);

  logic [mpm_pkg::WORD_W-1:0]   mem [mpm_pkg::TILE_PIXELS];
  logic [mpm_pkg::WORD_W-1:0]   rd_data_r;
  logic [mpm_pkg::ADDR_W-1:0]   wr_addr;
  logic [mpm_pkg::WORD_W-1:0]   wr_data;
  logic                         wr_en;

  logic [mpm_pkg::ADDR_W-1:0]   clr_addr_r;
  logic [mpm_pkg::ADDR_W-1:0]   clr_addr_nxt;
  logic [mpm_pkg::SAMPLE_W-1:0] null_r;

  logic [mpm_pkg::IDX_W-1:0]    idx_r;
  logic [mpm_pkg::SAMPLE_W-1:0] sample_r;
  logic                         last_r;
  logic                         in_tile_r;
  logic                         in_tile;

  logic [mpm_pkg::SUM_W-1:0]    sum_old;
  logic [mpm_pkg::CNT_W-1:0]    cnt_old;
  logic [mpm_pkg::SUM_W:0]      sum_add;
  logic [mpm_pkg::SUM_W-1:0]    sum_new;
  logic [mpm_pkg::CNT_W-1:0]    cnt_new;
  logic                         take;

  logic [mpm_pkg::CNT_W-1:0]    cnt_hold_r;
  logic [mpm_pkg::NUM_W-1:0]    div_num;
  logic [mpm_pkg::DEN_W-1:0]    div_den;
  logic                         div_done;
  logic [mpm_pkg::NUM_W-1:0]    quot;
  logic signed [mpm_pkg::TEMP_W-1:0] temp_val;

  logic                         out_valid_r;
  logic [mpm_pkg::IDX_W-1:0]    out_idx_r;
  logic signed [mpm_pkg::TEMP_W-1:0] out_temp_r;
  logic [mpm_pkg::CNT_W-1:0]    out_cnt_r;

  assign in_tile = ({1'b0, in_pixel_index} < (mpm_pkg::IDX_W+1)'(mpm_pkg::TILE_PIXELS));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_r <= '0;
    end else if (cfg_we) begin
      null_r <= cfg_null_value;
    end
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r     <= in_pixel_index;
      sample_r  <= in_sample_value;
      last_r    <= in_last_image;
      in_tile_r <= in_tile;
    end
  end

  // accumulate, out-of-tile pixels read as empty
  always_comb begin
    sum_old = in_tile_r ? rd_data_r[mpm_pkg::WORD_W-1:mpm_pkg::CNT_W] : '0;
    cnt_old = in_tile_r ? rd_data_r[mpm_pkg::CNT_W-1:0] : '0;
    take    = (sample_r != null_r) && (cnt_old < mpm_pkg::CNT_W'(mpm_pkg::COUNT_LIMIT));
    sum_add = {1'b0, sum_old} + {{(mpm_pkg::SUM_W+1-mpm_pkg::SAMPLE_W){1'b0}}, sample_r};
    sum_new = sum_old;
    cnt_new = cnt_old;
    if (take) begin
      sum_new = sum_add[mpm_pkg::SUM_W] ? '1 : sum_add[mpm_pkg::SUM_W-1:0];
      cnt_new = cnt_old + 1'b1;
    end
    div_num = {1'b0, sum_new, 2'b00} + {{(mpm_pkg::NUM_W-mpm_pkg::CNT_W){1'b0}}, cnt_new};
    div_den = {cnt_new, 1'b0};
  end

  // clearing pass counter
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (cmd.clear_wr) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // single write port: clearing pass or write-back
  always_comb begin
    wr_en   = cmd.clear_wr || (cmd.update_wr && in_tile_r);
    wr_addr = cmd.clear_wr ? clr_addr_r : idx_r[mpm_pkg::ADDR_W-1:0];
    wr_data = (cmd.clear_wr || last_r) ? '0 : {sum_new, cnt_new};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[in_pixel_index[mpm_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      cnt_hold_r <= cnt_new;
    end
  end

  mpm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // zero for an empty pixel, else subtract the kelvin offset and clamp high
  always_comb begin
    if (cnt_hold_r == '0) begin
      temp_val = '0;
    end else if (quot > mpm_pkg::NUM_W'(mpm_pkg::QUOT_CLAMP)) begin
      temp_val = mpm_pkg::TEMP_W'(mpm_pkg::TEMP_MAX);
    end else begin
      temp_val = quot[mpm_pkg::TEMP_W-1:0] - mpm_pkg::TEMP_W'(mpm_pkg::KELVIN_OFFSET);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= idx_r;
      out_temp_r <= temp_val;
      out_cnt_r  <= cnt_hold_r;
    end
  end

  assign sts.clear_done = (clr_addr_r == mpm_pkg::ADDR_W'(mpm_pkg::TILE_PIXELS - 1));
  assign sts.last_item  = last_r;
  assign sts.div_done   = div_done;

  assign out_valid           = out_valid_r;
  assign out_pixel_index_out = out_idx_r;
  assign out_temperature     = out_temp_r;
  assign out_valid_count     = out_cnt_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r == '0) |-> out_temp_r == '0)
    else $error("empty pixel gave nonzero temperature");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r <= mpm_pkg::CNT_W'(mpm_pkg::COUNT_LIMIT))
    else $error("reported count above limit");

endmodule

// ----- sv/mpm_ctrl.sv -----
// controller: clearing pass, accept, update and divide sequencing
module mpm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output mpm_pkg::cmd_t cmd,
  input  mpm_pkg::sts_t sts
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update_wr = 1'b1;
        if (sts.last_item) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_UPD)
    else $error("accepted word not followed by update");

  a_div_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (state_r == S_UPD && sts.last_item))
    else $error("divide started without last-image word");

  a_emit_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !busy)
    else $error("block busy after result issued");

endmodule

// ----- sv/masked_pixel_mean_lst_top.sv -----
// top level of the masked per-pixel mean temperature block
// After reset the block runs a clearing pass over the 4096-entry pixel store
// and holds busy high while it runs. A word is taken when start is high and
// busy is low. A word without the last-image flag keeps busy high through its
// write-back (read, then write-back of the pixel store), so the block takes
// the next word only once that is done. A last-image word keeps busy high
// through write-back and bit-serial divide (27 quotient bits, one per cycle);
// its result appears on the out_ ports for a single cycle, marked by
// out_valid, right after busy falls. The receiver cannot stall the block and
// must take each result in that cycle. Write cfg_null_value only while idle.
module masked_pixel_mean_lst_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mpm_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [mpm_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                         in_last_image,
  output logic                         out_valid,
  output logic [mpm_pkg::IDX_W-1:0]    out_pixel_index_out,
  output logic signed [mpm_pkg::TEMP_W-1:0] out_temperature,
  output logic [mpm_pkg::CNT_W-1:0]    out_valid_count,
  input  logic                         cfg_we,
  input  logic [mpm_pkg::SAMPLE_W-1:0] cfg_null_value
);

  mpm_pkg::cmd_t cmd;
  mpm_pkg::sts_t sts;

  mpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  mpm_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_null_value      (cfg_null_value),
    .in_pixel_index      (in_pixel_index),
    .in_sample_value     (in_sample_value),
    .in_last_image       (in_last_image),
    .out_valid           (out_valid),
    .out_pixel_index_out (out_pixel_index_out),
    .out_temperature     (out_temperature),
    .out_valid_count     (out_valid_count)
  );

endmodule

// ----- test/mpm_mean_checker.sv -----
// checker: watches the ports of the masked pixel mean block, predicts and compares results
module mpm_mean_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [mpm_pkg::IDX_W-1:0]         in_pixel_index,
  input  logic [mpm_pkg::SAMPLE_W-1:0]      in_sample_value,
  input  logic                              in_last_image,
  input  logic                              out_valid,
  input  logic [mpm_pkg::IDX_W-1:0]         out_pixel_index_out,
  input  logic signed [mpm_pkg::TEMP_W-1:0] out_temperature,
  input  logic [mpm_pkg::CNT_W-1:0]         out_valid_count,
  input  logic                              cfg_we,
  input  logic [mpm_pkg::SAMPLE_W-1:0]      cfg_null_value,
  output int                                pending_results,
  output int                                mismatch_count
);

  localparam logic [mpm_pkg::SUM_W-1:0] SUM_SAT = {mpm_pkg::SUM_W{1'b1}};

  typedef struct packed {
    logic [mpm_pkg::IDX_W-1:0]         pixel;
    logic signed [mpm_pkg::TEMP_W-1:0] temp;
    logic [mpm_pkg::CNT_W-1:0]         count;
  } mean_word_t;

  logic [mpm_pkg::SUM_W-1:0]    pix_sum [mpm_pkg::TILE_PIXELS];
  logic [mpm_pkg::CNT_W-1:0]    pix_cnt [mpm_pkg::TILE_PIXELS];
  logic [mpm_pkg::SAMPLE_W-1:0] null_val;
  mean_word_t                   mean_q [$];
  int                           errs = 0;
  int                           k;

  always @(posedge clk) begin : model
    logic [mpm_pkg::SUM_W-1:0] s;
    logic [mpm_pkg::CNT_W-1:0] c;
    logic [mpm_pkg::SUM_W:0]   wide;
    longint                    q;
    mean_word_t                w;

    if (!rst_n) begin
      for (k = 0; k < mpm_pkg::TILE_PIXELS; k++) begin
        pix_sum[k] = '0;
        pix_cnt[k] = '0;
      end
      null_val = '0;
      mean_q.delete();
    end else begin
      // result leaving this cycle belongs to an older word, so compare first
      if (out_valid) begin
        if (mean_q.size() == 0) begin
          errs++;
          $display("%0t unexpected result word: expected none, got pixel %0d temp %0d count %0d",
                   $time, out_pixel_index_out, out_temperature, out_valid_count);
        end else begin
          w = mean_q.pop_front();
          if (out_pixel_index_out !== w.pixel) begin
            errs++;
            $display("%0t pixel_index_out mismatch: expected %0d, got %0d",
                     $time, w.pixel, out_pixel_index_out);
          end
          if (out_temperature !== w.temp) begin
            errs++;
            $display("%0t temperature mismatch (pixel %0d): expected %0d, got %0d",
                     $time, w.pixel, w.temp, out_temperature);
          end
          if (out_valid_count !== w.count) begin
            errs++;
            $display("%0t valid_count mismatch (pixel %0d): expected %0d, got %0d",
                     $time, w.pixel, w.count, out_valid_count);
          end
        end
      end

      if (start && !busy) begin
        s = pix_sum[in_pixel_index];
        c = pix_cnt[in_pixel_index];
        if (in_sample_value != null_val && c < mpm_pkg::COUNT_LIMIT) begin
          wide = s + in_sample_value;
          s    = (wide > SUM_SAT) ? SUM_SAT : wide[mpm_pkg::SUM_W-1:0];
          c    = c + 1'b1;
        end
        pix_sum[in_pixel_index] = s;
        pix_cnt[in_pixel_index] = c;
        if (in_last_image) begin
          // rounded 2*sum/count, halves up, then shifted to centi-celsius
          if (c == 0) begin
            q = 0;
          end else begin
            q = (4 * longint'(s) + longint'(c)) / (2 * longint'(c)) - mpm_pkg::KELVIN_OFFSET;
            if (q > mpm_pkg::TEMP_MAX) q = mpm_pkg::TEMP_MAX;
            if (q < -mpm_pkg::TEMP_MAX - 1) q = -mpm_pkg::TEMP_MAX - 1;
          end
          w.pixel = in_pixel_index;
          w.temp  = q[mpm_pkg::TEMP_W-1:0];
          w.count = c;
          mean_q.insert(mean_q.size(), w);
          pix_sum[in_pixel_index] = '0;
          pix_cnt[in_pixel_index] = '0;
        end
      end

      if (cfg_we) null_val = cfg_null_value;
    end
    pending_results <= mean_q.size();
    mismatch_count  <= errs;
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top: clock, reset, stimulus and verdict for the masked pixel mean block
module tb_top;

  localparam int STALL_LIMIT = 12000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [mpm_pkg::IDX_W-1:0]         in_pixel_index = '0;
  logic [mpm_pkg::SAMPLE_W-1:0]      in_sample_value = '0;
  logic                              in_last_image = 1'b0;
  logic                              out_valid;
  logic [mpm_pkg::IDX_W-1:0]         out_pixel_index_out;
  logic signed [mpm_pkg::TEMP_W-1:0] out_temperature;
  logic [mpm_pkg::CNT_W-1:0]         out_valid_count;
  logic                              cfg_we = 1'b0;
  logic [mpm_pkg::SAMPLE_W-1:0]      cfg_null_value = '0;
  int                                pending_results;
  int                                mismatch_count;
  int                                stall_cycles = 0;
  logic [mpm_pkg::SAMPLE_W-1:0]      cur_null = '0;

  always #2 clk = ~clk;

  masked_pixel_mean_lst_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel_index      (in_pixel_index),
    .in_sample_value     (in_sample_value),
    .in_last_image       (in_last_image),
    .out_valid           (out_valid),
    .out_pixel_index_out (out_pixel_index_out),
    .out_temperature     (out_temperature),
    .out_valid_count     (out_valid_count),
    .cfg_we              (cfg_we),
    .cfg_null_value      (cfg_null_value)
  );

  mpm_mean_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel_index      (in_pixel_index),
    .in_sample_value     (in_sample_value),
    .in_last_image       (in_last_image),
    .out_valid           (out_valid),
    .out_pixel_index_out (out_pixel_index_out),
    .out_temperature     (out_temperature),
    .out_valid_count     (out_valid_count),
    .cfg_we              (cfg_we),
    .cfg_null_value      (cfg_null_value),
    .pending_results     (pending_results),
    .mismatch_count      (mismatch_count)
  );

  // cycles with neither a word taken nor a result out
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // returns at the edge where the word is taken; start stays high
  task automatic send_word(input logic [mpm_pkg::IDX_W-1:0] idx,
                           input logic [mpm_pkg::SAMPLE_W-1:0] smp,
                           input logic last);
    start           <= 1'b1;
    in_pixel_index  <= idx;
    in_sample_value <= smp;
    in_last_image   <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic rest();
    start <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    // pending count is registered from the checker's queue size
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_null(input logic [mpm_pkg::SAMPLE_W-1:0] v);
    drain_results();
    // a word without result may still be in its write-back
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_null_value <= v;
    cur_null       = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n, input bit idling);
    int                           hot [16];
    int                           j;
    int                           mode;
    bit                           quiet;
    logic [mpm_pkg::IDX_W-1:0]    idx;
    logic [mpm_pkg::SAMPLE_W-1:0] smp;
    logic                         last;

    for (j = 0; j < 16; j++) hot[j] = $urandom_range(0, mpm_pkg::TILE_PIXELS - 1);
    quiet = 1'b0;
    for (j = 0; j < n; j++) begin
      if (j % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (idling && j == n / 2) drain_results();
      if (idling && !quiet && $urandom_range(0, 4) == 0) rest();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        // noise: any pixel, any sample
        idx  = mpm_pkg::IDX_W'($urandom_range(0, mpm_pkg::TILE_PIXELS - 1));
        smp  = mpm_pkg::SAMPLE_W'($urandom_range(0, 65535));
        last = 1'($urandom_range(0, 1));
      end else begin
        idx = mpm_pkg::IDX_W'(hot[$urandom_range(0, 15)]);
        case ($urandom_range(0, 9))
          0, 1:    smp = cur_null;
          2:       smp = '0;
          3:       smp = '1;
          default: smp = mpm_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
        last = ($urandom_range(0, 7) == 0);
      end
      send_word(idx, smp, last);
    end
  endtask

  initial begin
    int n;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_null('0);

    // empty pixel, null sample on a last word
    send_word(12'd0, 16'd0, 1'b1);
    send_word(12'd4095, 16'hFFFF, 1'b0);
    send_word(12'd4095, 16'hFFFF, 1'b1);
    send_word(12'd1, 16'd1, 1'b1);
    // sum 5 over 4 samples: half rounds up
    send_word(12'd2, 16'd2, 1'b0);
    send_word(12'd2, 16'd1, 1'b0);
    send_word(12'd2, 16'd1, 1'b0);
    send_word(12'd2, 16'd1, 1'b1);
    send_word(12'd5, 16'd0, 1'b0);
    send_word(12'd5, 16'd100, 1'b0);
    send_word(12'd5, 16'd0, 1'b1);
    // count saturates at the image limit, extra samples dropped
    for (n = 0; n < mpm_pkg::COUNT_LIMIT + 2; n++)
      send_word(12'd3, 16'hFFFF, n == mpm_pkg::COUNT_LIMIT + 1);

    write_null(16'hFFFF);
    send_word(12'd10, 16'hFFFF, 1'b1);
    send_word(12'd11, 16'd0, 1'b0);
    send_word(12'd11, 16'd0, 1'b1);
    send_word(12'd12, 16'hFFFE, 1'b1);

    write_null(mpm_pkg::SAMPLE_W'($urandom_range(1, 65534)));
    run_random(294, 1'b1);
    write_null('0);
    run_random(294, 1'b1);
    write_null(16'hFFFF);
    run_random(294, 1'b1);
    write_null(mpm_pkg::SAMPLE_W'($urandom_range(0, 65535)));
    run_random(294, 1'b0);

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
